// ===== rtl/core/mrb_pkg.sv =====
// Shared constants and types for the max rectangle binary grid block.
package mrb_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int HGT_W  = $clog2(MAX_ROWS + 1);
    localparam int CFG_W  = 11;
    localparam int AREA_W = 21;
    localparam int PROD_W = HGT_W + CNT_W;

    localparam logic [CNT_W-1:0]  COLS_MAX  = CNT_W'(MAX_COLS);
    localparam logic [HGT_W:0]    ROWS_MAX  = (HGT_W + 1)'(MAX_ROWS);
    localparam logic [AREA_W-1:0] AREA_SAT  = {AREA_W{1'b1}};

    typedef struct packed {
        logic [HGT_W-1:0] hgt;
        logic [COL_W-1:0] idx;
    } t_stk_entry;

    localparam int STK_W = $bits(t_stk_entry);

endpackage

// ===== rtl/core/mrb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/max_rectangle_binary_grid_top.sv =====
// Top level of the max rectangle binary grid block: heights, histogram stack, results.
//
// Cells arrive one per beat in row order. Each cell is accepted, its column height is read
// from the height RAM, bars taller than it are popped and it is pushed onto the stack RAM;
// the row's last cell then pops every bar left on the stack, and the row is closed and the
// result loaded once the result register is free. Each column is pushed and popped once per
// row. The height RAM has a registered read and the stack RAM takes one push or one pop per
// cycle. Heights and stack need no clearing after reset. The result register lets the next
// row start while a result waits.
module max_rectangle_binary_grid_top
    import mrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,     // num_columns
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [0] cell_free, rest zero
    input  logic              s_axis_tlast,   // last_in_grid
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // [20:0] row_best_area, [41:21] grid_best_area
    output logic              m_axis_tlast    // grid_done
);

    typedef enum logic [1:0] {S_IDLE, S_HGT, S_POP, S_FIN} t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_num_cols;
    logic [COL_W-1:0]   r_pos;
    logic               r_first;
    logic [AREA_W-1:0]  r_row_best;
    logic [AREA_W-1:0]  r_grid_best;
    logic [COL_W-1:0]   r_c;
    logic               r_free;
    logic               r_last;
    logic               r_row_end;
    logic               r_flush;
    logic [HGT_W-1:0]   r_h;
    logic [CNT_W-1:0]   r_depth;
    t_stk_entry         r_top;
    t_stk_entry         r_sec;
    logic               r_sec_ram;
    logic [AREA_W-1:0]  r_area;
    logic               r_area_v;
    logic               r_out_valid;
    logic [AREA_W-1:0]  r_out_row;
    logic [AREA_W-1:0]  r_out_grid;
    logic               r_out_done;

    logic [CNT_W-1:0]   cols;
    logic [COL_W-1:0]   c_cur;
    logic               in_acc;
    logic               out_free;

    logic [HGT_W-1:0]   hgt_rdata;
    logic               hgt_we;
    logic [HGT_W:0]     hgt_sum;
    logic [HGT_W-1:0]   n_h;

    t_stk_entry         stk_rdata;
    t_stk_entry         sec;
    logic               stk_we;
    logic               stk_re;
    logic [COL_W-1:0]   stk_raddr;

    logic [HGT_W-1:0]   top_h;
    logic               do_pop;
    logic               do_push;
    logic [CNT_W-1:0]   right;
    logic [CNT_W-1:0]   width;
    logic [PROD_W-1:0]  prod;
    logic [AREA_W-1:0]  n_area;
    logic [AREA_W-1:0]  grid_new;

    // clamp the column count to 1..MAX_COLS
    always_comb begin
        if (r_num_cols == '0) begin
            cols = CNT_W'(1);
        end else if (r_num_cols > CFG_W'(COLS_MAX)) begin
            cols = COLS_MAX;
        end else begin
            cols = CNT_W'(r_num_cols);
        end
    end

    always_comb begin
        if (CNT_W'(r_pos) >= cols) begin
            c_cur = COL_W'(cols - CNT_W'(1));
        end else begin
            c_cur = r_pos;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    mrb_ram #(.WIDTH(HGT_W), .DEPTH(MAX_COLS)) u_hgt_ram (
        .i_clk   (i_clk),
        .i_we    (hgt_we),
        .i_waddr (r_c),
        .i_wdata (n_h),
        .i_re    (in_acc),
        .i_raddr (c_cur),
        .o_rdata (hgt_rdata)
    );

    assign hgt_we  = (r_state == S_HGT);
    assign hgt_sum = {1'b0, hgt_rdata} + (HGT_W + 1)'(1);

    always_comb begin
        if (!r_free) begin
            n_h = '0;
        end else if (r_first) begin
            n_h = HGT_W'(1);
        end else if (hgt_sum > ROWS_MAX) begin
            n_h = HGT_W'(ROWS_MAX);
        end else begin
            n_h = HGT_W'(hgt_sum);
        end
    end

    mrb_ram #(.WIDTH(STK_W), .DEPTH(MAX_COLS)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[COL_W-1:0]),
        .i_wdata ({r_h, r_c}),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign sec = r_sec_ram ? stk_rdata : r_sec;

    // a column rewritten after a mid-row shrink scores with its new height
    assign top_h = (r_top.idx == r_c) ? r_h : r_top.hgt;

    assign do_pop  = (r_state == S_POP) && (r_depth != '0) && (r_flush || top_h > r_h);
    assign do_push = (r_state == S_POP) && !do_pop && !r_flush && (r_depth < COLS_MAX);
    assign stk_we  = do_push;
    assign stk_re  = do_pop && (r_depth >= CNT_W'(3));
    assign stk_raddr = COL_W'(r_depth - CNT_W'(3));

    assign right = r_flush ? cols : CNT_W'(r_c);

    always_comb begin
        if (r_depth >= CNT_W'(2)) begin
            if (right > CNT_W'(sec.idx)) begin
                width = right - CNT_W'(sec.idx) - CNT_W'(1);
            end else begin
                width = '0;
            end
        end else begin
            width = right;
        end
    end

    assign prod   = PROD_W'(top_h) * PROD_W'(width);
    assign n_area = (prod > PROD_W'(AREA_SAT)) ? AREA_SAT : AREA_W'(prod);

    assign grid_new = (r_row_best > r_grid_best) ? r_row_best : r_grid_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_cols  <= CFG_W'(MAX_COLS);
            r_pos       <= '0;
            r_first     <= 1'b1;
            r_row_best  <= '0;
            r_grid_best <= '0;
            r_flush     <= 1'b0;
            r_depth     <= '0;
            r_sec_ram   <= 1'b0;
            r_area_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_cols <= i_cfg_data;
            end
            if (r_out_valid && m_axis_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            r_area_v <= do_pop;
            r_area   <= n_area;
            if (r_area_v && r_area > r_row_best) begin
                r_row_best <= r_area;
            end

            if (do_pop) begin
                r_depth <= r_depth - CNT_W'(1);
                r_top   <= sec;
                if (r_depth >= CNT_W'(3)) begin
                    r_sec_ram <= 1'b1;
                end
            end
            if (do_push) begin
                r_depth   <= r_depth + CNT_W'(1);
                r_top     <= {r_h, r_c};
                r_sec     <= r_top;
                r_sec_ram <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_c       <= c_cur;
                        r_free    <= s_axis_tdata[0];
                        r_last    <= s_axis_tlast;
                        r_row_end <= (CNT_W'(c_cur) == cols - CNT_W'(1));
                        r_state   <= S_HGT;
                    end
                end
                S_HGT: begin
                    r_h     <= n_h;
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_flush) begin
                        if (r_depth == '0) begin
                            r_state <= S_FIN;
                        end
                    end else if (!do_pop) begin
                        if (r_row_end) begin
                            r_flush <= 1'b1;
                        end else begin
                            r_pos   <= r_c + COL_W'(1);
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_row_best;
                        r_out_grid  <= grid_new;
                        r_out_done  <= r_last;
                        r_grid_best <= r_last ? '0 : grid_new;
                        r_first     <= r_last;
                        r_row_best  <= '0;
                        r_pos       <= '0;
                        r_depth     <= '0;
                        r_flush     <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_grid, r_out_row};
    assign m_axis_tlast  = r_out_done;

endmodule
